### hw/rtl/pbma_pkg.sv
// Shared constants for the PIM batch mode arbiter.
package pbma_pkg;

  // Configuration write channel shape.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATCHES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_QUEUE_EN  = 1'b1;

  // Batch counter width and its saturation value.
  localparam int BATCH_CNT_W = 8;
  localparam logic [BATCH_CNT_W-1:0] BATCH_CNT_MAX = '1;

  // Reset value of the minimum batch count register.
  localparam logic [BATCH_CNT_W-1:0] MIN_BATCHES_RST = 8'd1;

  // Input item kinds carried on in_tuser.
  localparam logic ACT_MODE_UPDATE = 1'b0;
  localparam logic ACT_PIM_ISSUED  = 1'b1;

endpackage

### hw/rtl/pim_batch_mode_arbiter_core.sv
// Top level of the PIM batch mode arbiter: input register, decision logic, result register.
// A beat accepted into the input stage is presented on out_tvalid once it moves into the result register.
// Throughput: one beat per cycle; each item's state update is done in one pass of
// logic between the input stage and the result register (subtract, two saturating adds).
// The input stage refills while the result register drains, so only a stall on
// out_tready holds back in_tready.
// Reset: synchronous on rst_n low; mode, batch state and registers return to their defaults.
module pim_batch_mode_arbiter_core #(
  parameter int ROW_BITS   = 16,
  parameter int CYCLE_BITS = 48,
  localparam int IN_W        = 3 + 2 * ROW_BITS + CYCLE_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = 4 + CYCLE_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata from bit 0: read_pending, write_pending, pim_pending, front_row,
  // issued_row, now_cycle, zero fill.
  input  logic [IN_TDATA_W-1:0]             in_tdata,
  // tuser: action (0 mode update, 1 PIM request issued).
  input  logic                              in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata from bit 0: pim_on, entered_pim, left_pim, batch_done, batch_time, zero fill.
  output logic [OUT_TDATA_W-1:0]            out_tdata,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbma_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int BW = pbma_pkg::BATCH_CNT_W;

  // Configuration registers.
  logic [BW-1:0] min_batches_r;
  logic          wq_en_r;

  // Input stage.
  logic                  s1_valid_r;
  logic                  s1_action_r;
  logic                  s1_rd_r, s1_wr_r, s1_pim_r;
  logic [ROW_BITS-1:0]   s1_front_r, s1_issued_r;
  logic [CYCLE_BITS-1:0] s1_now_r;

  // Arbiter state.
  logic                  mode_pim_r, mode_pim_nxt;
  logic                  active_r, active_nxt;
  logic [CYCLE_BITS-1:0] start_r, start_nxt;
  logic [CYCLE_BITS-1:0] acc_r, acc_nxt;
  logic [BW-1:0]         bcnt_r, bcnt_nxt;
  logic [ROW_BITS-1:0]   last_row_r, last_row_nxt;
  logic [CYCLE_BITS-1:0] sw_time_r, sw_time_nxt;

  // Result register.
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic                  advance;
  logic                  normal_work;
  logic                  done, entered, left_mode;
  logic [CYCLE_BITS-1:0] btime;
  logic [CYCLE_BITS:0]   acc_sum, sw_sum;
  logic [CYCLE_BITS-1:0] acc_upd;
  logic [BW-1:0]         bcnt_upd;

  // The input stage moves on whenever the result register is free or draining.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_batches_r <= pbma_pkg::MIN_BATCHES_RST;
      wq_en_r       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbma_pkg::CFG_MIN_BATCHES: min_batches_r <= cfg_data[BW-1:0];
        pbma_pkg::CFG_WR_QUEUE_EN: wq_en_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input stage capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser;
      s1_rd_r     <= in_tdata[0];
      s1_wr_r     <= in_tdata[1];
      s1_pim_r    <= in_tdata[2];
      s1_front_r  <= in_tdata[3 +: ROW_BITS];
      s1_issued_r <= in_tdata[3 + ROW_BITS +: ROW_BITS];
      s1_now_r    <= in_tdata[3 + 2 * ROW_BITS +: CYCLE_BITS];
    end
  end

  // Mode decision for the item in the input stage.
  always_comb begin
    mode_pim_nxt = mode_pim_r;
    active_nxt   = active_r;
    start_nxt    = start_r;
    acc_nxt      = acc_r;
    bcnt_nxt     = bcnt_r;
    last_row_nxt = last_row_r;
    sw_time_nxt  = sw_time_r;
    done         = 1'b0;
    entered      = 1'b0;
    left_mode    = 1'b0;

    normal_work = s1_rd_r || (s1_wr_r && wq_en_r);
    btime       = s1_now_r - start_r;

    // Close the batch: accumulate its time and push out the switch-back time.
    acc_sum  = {1'b0, acc_r} + {1'b0, btime};
    acc_upd  = acc_sum[CYCLE_BITS] ? '1 : acc_sum[CYCLE_BITS-1:0];
    sw_sum   = {1'b0, s1_now_r} + {1'b0, acc_upd};
    bcnt_upd = (bcnt_r == pbma_pkg::BATCH_CNT_MAX) ? bcnt_r : bcnt_r + 1'b1;

    if (s1_action_r == pbma_pkg::ACT_PIM_ISSUED) begin
      if (!active_r) begin
        active_nxt = 1'b1;
        start_nxt  = s1_now_r;
      end
      last_row_nxt = s1_issued_r;
    end else if (mode_pim_r) begin
      done = active_r && (!s1_pim_r || (s1_front_r != last_row_r));
      if (done) begin
        active_nxt  = 1'b0;
        acc_nxt     = acc_upd;
        bcnt_nxt    = bcnt_upd;
        sw_time_nxt = sw_sum[CYCLE_BITS] ? '1 : sw_sum[CYCLE_BITS-1:0];
      end
      if (((bcnt_nxt >= min_batches_r) || !s1_pim_r) && normal_work) begin
        acc_nxt      = '0;
        bcnt_nxt     = '0;
        mode_pim_nxt = 1'b0;
        left_mode    = 1'b1;
      end
    end else begin
      if (s1_pim_r && ((s1_now_r > sw_time_r) || !normal_work)) begin
        mode_pim_nxt = 1'b1;
        entered      = 1'b1;
      end
    end

    out_data_nxt = {(done ? btime : {CYCLE_BITS{1'b0}}), done, left_mode, entered,
                    mode_pim_nxt};
  end

  // State update, once per item leaving the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_pim_r <= 1'b0;
      active_r   <= 1'b0;
      start_r    <= '0;
      acc_r      <= '0;
      bcnt_r     <= '0;
      last_row_r <= '0;
      sw_time_r  <= '0;
    end else if (s1_valid_r && advance) begin
      mode_pim_r <= mode_pim_nxt;
      active_r   <= active_nxt;
      start_r    <= start_nxt;
      acc_r      <= acc_nxt;
      bcnt_r     <= bcnt_nxt;
      last_row_r <= last_row_nxt;
      sw_time_r  <= sw_time_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

### hw/rtl/pbma_checker.sv
// Port-level assertions for the PIM batch mode arbiter, bound to the top level.
module pbma_checker #(
  parameter int OUT_TDATA_W = 56,
  parameter int CYCLE_BITS  = 48
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic out_beat;
  assign out_beat = out_tvalid && out_tready;

  // A switch into PIM mode must show PIM mode on the same beat.
  a_enter_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_tdata[1]) |-> out_tdata[0])
    else $error("entered_pim without PIM mode shown");

  // A switch back to normal mode must show normal mode and not an entry too.
  a_leave_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_tdata[2]) |-> (!out_tdata[0] && !out_tdata[1]))
    else $error("left_pim inconsistent with mode");

  // Batch time is reported only with a finished batch.
  a_btime_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && !out_tdata[3]) |-> (out_tdata[4 +: CYCLE_BITS] == '0))
    else $error("batch_time set without batch_done");

  // Two consecutive beats cannot both switch into PIM mode.
  a_no_double_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_tdata[1]) ##1 out_beat |-> !out_tdata[1])
    else $error("entered_pim twice in a row");

  // A stalled result beat holds its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed under stall");

endmodule

bind pim_batch_mode_arbiter_core pbma_checker #(
  .OUT_TDATA_W(OUT_TDATA_W),
  .CYCLE_BITS (CYCLE_BITS)
) u_pbma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

### tb/tb_pim_batch_mode_arbiter_core.sv
// Self-checking testbench for the PIM batch mode arbiter core.
`timescale 1ns / 100ps

module tb_pim_batch_mode_arbiter_core;

  localparam int ROW_BITS    = 16;
  localparam int CYCLE_BITS  = 48;
  localparam int IN_TDATA_W  = ((3 + 2 * ROW_BITS + CYCLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 + CYCLE_BITS + 7) / 8) * 8;
  localparam logic [CYCLE_BITS-1:0] CYC_MAX = '1;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int SAT_BATCHES = 120;
  localparam int RAND_BEATS = 62;

  // Input beat fields, bit 0 of tdata in the lowest position.
  typedef struct packed {
    logic [CYCLE_BITS-1:0] now;
    logic [ROW_BITS-1:0]   issued;
    logic [ROW_BITS-1:0]   front;
    logic                  pim;
    logic                  wr;
    logic                  rd;
  } arb_req_t;

  // Result beat fields, bit 0 of tdata in the lowest position.
  typedef struct packed {
    logic [CYCLE_BITS-1:0] btime;
    logic                  done;
    logic                  left;
    logic                  entered;
    logic                  pim_on;
  } arb_res_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [IN_TDATA_W-1:0]              in_tdata;
  logic                               in_tuser;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]             out_tdata;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [pbma_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [pbma_pkg::CFG_DATA_W-1:0]    cfg_data;

  // Arbiter state as the testbench tracks it.
  logic                  pim_on_q;
  logic                  batch_open_q;
  logic [CYCLE_BITS-1:0] batch_start_q;
  logic [CYCLE_BITS-1:0] accum_cycles_q;
  logic [7:0]            batches_done_q;
  logic [ROW_BITS-1:0]   last_row_q;
  logic [CYCLE_BITS-1:0] switch_at_q;
  logic [7:0]            min_batches_q;
  logic                  wq_enable_q;

  arb_res_t              expected_results[$];
  int                    err_cnt;
  int                    result_cnt;
  int                    cycle_cnt;
  bit                    no_idle;
  logic [CYCLE_BITS-1:0] now_q;
  logic [ROW_BITS-1:0]   cur_row_q;

  pim_batch_mode_arbiter_core #(
    .ROW_BITS  (ROW_BITS),
    .CYCLE_BITS(CYCLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counts saturate at the all-ones value.
  function automatic logic [CYCLE_BITS-1:0] sat_add(logic [CYCLE_BITS-1:0] a,
                                                    logic [CYCLE_BITS-1:0] b);
    logic [CYCLE_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CYCLE_BITS] ? CYC_MAX : sum[CYCLE_BITS-1:0];
  endfunction

  // Applies one accepted beat to the tracked state and returns its result.
  function automatic arb_res_t arbiter_decide(logic act, arb_req_t r);
    arb_res_t res;
    logic     normal_work;
    res = '0;
    normal_work = r.rd || (r.wr && wq_enable_q);
    if (act == pbma_pkg::ACT_PIM_ISSUED) begin
      if (!batch_open_q) begin
        batch_open_q = 1'b1;
        batch_start_q = r.now;
      end
      last_row_q = r.issued;
    end else if (pim_on_q) begin
      // A batch closes when the queue drains or the row moves on.
      if (batch_open_q && (!r.pim || r.front != last_row_q)) begin
        res.btime = r.now - batch_start_q;
        batch_open_q = 1'b0;
        accum_cycles_q = sat_add(accum_cycles_q, res.btime);
        if (batches_done_q != pbma_pkg::BATCH_CNT_MAX) begin
          batches_done_q = batches_done_q + 8'd1;
        end
        switch_at_q = sat_add(r.now, accum_cycles_q);
        res.done = 1'b1;
      end
      if ((batches_done_q >= min_batches_q || !r.pim) && normal_work) begin
        accum_cycles_q = '0;
        batches_done_q = '0;
        pim_on_q = 1'b0;
        res.left = 1'b1;
      end
    end else if (r.pim && (r.now > switch_at_q || !normal_work)) begin
      pim_on_q = 1'b1;
      res.entered = 1'b1;
    end
    res.pim_on = pim_on_q;
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [CYCLE_BITS-1:0] want,
                                        logic [CYCLE_BITS-1:0] seen);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("result %0d: %s expected %0h, got %0h", result_cnt, what, want, seen);
    end
  endfunction

  // Receiver side: random backpressure unless a quiet stretch is running.
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  // Compares every result beat with the oldest outstanding expectation.
  always @(posedge clk) begin
    arb_res_t got;
    arb_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = arb_res_t'(out_tdata[$bits(arb_res_t)-1:0]);
      if (expected_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("result %0d arrived with none outstanding: %h", result_cnt, got);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.pim_on !== want.pim_on) begin
          note_mismatch("pim_on", CYCLE_BITS'(want.pim_on), CYCLE_BITS'(got.pim_on));
        end
        if (got.entered !== want.entered) begin
          note_mismatch("entered_pim", CYCLE_BITS'(want.entered), CYCLE_BITS'(got.entered));
        end
        if (got.left !== want.left) begin
          note_mismatch("left_pim", CYCLE_BITS'(want.left), CYCLE_BITS'(got.left));
        end
        if (got.done !== want.done) begin
          note_mismatch("batch_done", CYCLE_BITS'(want.done), CYCLE_BITS'(got.done));
        end
        if (got.btime !== want.btime) note_mismatch("batch_time", want.btime, got.btime);
      end
      result_cnt++;
    end
  end

  // Sends one beat, with an occasional gap before it, and records its result.
  task automatic send_beat(input logic act, input arb_req_t r);
    if (!no_idle && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {{(IN_TDATA_W - $bits(arb_req_t)){1'b0}}, r};
    do @(posedge clk); while (!in_tready);
    expected_results.insert(expected_results.size(), arbiter_decide(act, r));
  endtask

  task automatic send_update(input logic rd, input logic wr, input logic pim,
                             input logic [ROW_BITS-1:0] front,
                             input logic [CYCLE_BITS-1:0] now);
    arb_req_t r;
    r = '0;
    r.rd = rd;
    r.wr = wr;
    r.pim = pim;
    r.front = front;
    r.now = now;
    send_beat(pbma_pkg::ACT_MODE_UPDATE, r);
  endtask

  task automatic send_issue(input logic [ROW_BITS-1:0] row,
                            input logic [CYCLE_BITS-1:0] now);
    arb_req_t r;
    r = '0;
    r.issued = row;
    r.front = ROW_BITS'($urandom);
    r.now = now;
    send_beat(pbma_pkg::ACT_PIM_ISSUED, r);
  endtask

  // Holds the sender until every outstanding result is back, then lets the pipe settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [pbma_pkg::CFG_IDX_W-1:0] idx,
                                input logic [pbma_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pbma_pkg::CFG_MIN_BATCHES) begin
      min_batches_q = value;
    end else begin
      wq_enable_q = value[0];
    end
    @(posedge clk);
  endtask

  // Mode entry and exit under the reset configuration, including a clock
  // that runs backwards and the switch time pinned at its ceiling.
  task automatic test_mode_switching();
    send_update(1'b0, 1'b0, 1'b0, 16'h0000, 48'd0);
    send_update(1'b1, 1'b0, 1'b1, 16'h0000, 48'd0);
    send_update(1'b1, 1'b0, 1'b1, 16'h0000, 48'd1);
    send_issue(16'hFFFF, 48'd10);
    send_update(1'b1, 1'b0, 1'b1, 16'hFFFF, 48'd20);
    send_update(1'b1, 1'b1, 1'b1, 16'h0000, 48'd5);
    send_issue(16'h0000, 48'd30);
    send_update(1'b1, 1'b0, 1'b1, 16'h0000, CYC_MAX);
    send_update(1'b0, 1'b1, 1'b1, 16'h0000, CYC_MAX);
    send_update(1'b0, 1'b1, 1'b1, 16'h0000, 48'd40);
    send_update(1'b1, 1'b0, 1'b0, 16'h0000, CYC_MAX);
    send_update(1'b1, 1'b0, 1'b1, 16'h0000, 48'd0);
  endtask

  // Writes count as normal work; with a zero batch minimum the block leaves
  // at once and the open batch carries over into the next PIM stretch.
  task automatic test_write_queue_rules();
    drain_results();
    write_register(pbma_pkg::CFG_WR_QUEUE_EN, 8'd1);
    write_register(pbma_pkg::CFG_MIN_BATCHES, 8'd0);
    send_update(1'b0, 1'b1, 1'b1, 16'h0000, 48'd5);
    send_update(1'b0, 1'b0, 1'b1, 16'h0000, 48'd6);
    send_issue(16'h1234, 48'd7);
    send_update(1'b0, 1'b1, 1'b1, 16'h1234, 48'd9);
    send_update(1'b0, 1'b0, 1'b1, 16'h1234, 48'd12);
    send_issue(16'h4321, 48'd13);
    send_update(1'b0, 1'b0, 1'b1, 16'h1234, 48'd20);
    send_update(1'b0, 1'b0, 1'b0, 16'h0000, 48'd21);
    send_update(1'b1, 1'b0, 1'b0, 16'h0000, 48'd22);
    send_update(1'b1, 1'b0, 1'b1, 16'h0000, 48'd33);
    send_update(1'b1, 1'b0, 1'b1, 16'h0000, 48'd34);
    now_q = 48'd100;
  endtask

  // Runs a long chain of batches with no normal work so the accumulated
  // time and the switch time hit their ceilings and stay there.
  task automatic test_batch_saturation();
    logic [ROW_BITS-1:0] row;
    drain_results();
    write_register(pbma_pkg::CFG_MIN_BATCHES, pbma_pkg::BATCH_CNT_MAX);
    write_register(pbma_pkg::CFG_WR_QUEUE_EN, 8'd0);
    send_update(1'b0, 1'b0, 1'b1, 16'h0000, now_q);
    for (int i = 0; i < SAT_BATCHES; i++) begin
      row = ROW_BITS'($urandom);
      now_q = (i < 2) ? 48'd1 : now_q + $urandom_range(0, 9);
      send_issue(row, now_q);
      now_q = (i < 2) ? CYC_MAX : now_q + $urandom_range(1, 30);
      // A different row always reaches the front, and the queue may also drain.
      send_update(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  row ^ 16'($urandom_range(1, 65535)), now_q);
      if (i == 1) now_q = 48'd200;
    end
    now_q = now_q + 48'd1;
    send_update(1'b1, 1'b0, 1'b1, 16'h0000, now_q);
  endtask

  // Mostly batch-shaped traffic around one current row, with the odd
  // random row and clock jump mixed in.
  task automatic test_random_traffic(input int n_beats, input logic [7:0] min_b,
                                     input logic wq_en, input bit quiet,
                                     input bit pressure);
    arb_req_t r;
    logic     act;
    int       pick;
    drain_results();
    write_register(pbma_pkg::CFG_MIN_BATCHES, min_b);
    write_register(pbma_pkg::CFG_WR_QUEUE_EN, {7'd0, wq_en});
    no_idle = quiet;
    for (int i = 0; i < n_beats; i++) begin
      if (pressure && i == n_beats / 2) drain_results();
      pick = $urandom_range(99);
      if (pick < 4) begin
        now_q = CYCLE_BITS'({$urandom, $urandom});
      end else if (pick < 7) begin
        now_q = CYC_MAX - $urandom_range(0, 40);
      end else begin
        now_q = now_q + $urandom_range(0, 12);
      end
      if ($urandom_range(99) < 15) cur_row_q = ROW_BITS'($urandom);
      r = '0;
      r.now = now_q;
      r.issued = ($urandom_range(99) < 90) ? cur_row_q : ROW_BITS'($urandom);
      r.front = ($urandom_range(99) < 75) ? cur_row_q : ROW_BITS'($urandom);
      r.pim = ($urandom_range(99) < 80);
      r.rd = 1'($urandom_range(1));
      r.wr = 1'($urandom_range(1));
      act = ($urandom_range(99) < 35) ? pbma_pkg::ACT_PIM_ISSUED : pbma_pkg::ACT_MODE_UPDATE;
      send_beat(act, r);
    end
    no_idle = 1'b0;
  endtask

  // Watchdog on the whole run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= pbma_pkg::ACT_MODE_UPDATE;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pbma_pkg::CFG_MIN_BATCHES;
    cfg_data <= '0;
    err_cnt = 0;
    result_cnt = 0;
    no_idle = 1'b0;
    now_q = '0;
    cur_row_q = '0;
    pim_on_q = 1'b0;
    batch_open_q = 1'b0;
    batch_start_q = '0;
    accum_cycles_q = '0;
    batches_done_q = '0;
    last_row_q = '0;
    switch_at_q = '0;
    min_batches_q = pbma_pkg::MIN_BATCHES_RST;
    wq_enable_q = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_mode_switching();
    test_write_queue_rules();
    test_batch_saturation();
    test_random_traffic(RAND_BEATS, 8'($urandom_range(1, 3)), 1'b0, 1'b0, 1'b0);
    test_random_traffic(RAND_BEATS, 8'd0, 1'b1, 1'b0, 1'b1);
    test_random_traffic(RAND_BEATS, 8'($urandom_range(2, 6)), 1'b1, 1'b1, 1'b0);
    drain_results();
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
